FILE: rtl/huffman_code_bit_packer_defines.svh
// assertion macros shared by the huffman bit packer rtl
// depends on clk_i and rst_ni being visible in the including module
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// checked only out of reset
`define HCBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hcbp assertion failed");

// checked on every edge, also during reset
`define HCBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hcbp assertion failed");

`endif

FILE: rtl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
// no dependencies
package hcbp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned SymW       = 8;
  localparam int unsigned CodeInW    = 32;
  localparam int unsigned LenInW     = 6;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned InDataW    = 48;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

endpackage

FILE: rtl/huffman_code_bit_packer.sv
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser=mode, tdata=symbol|code_bits|code_length
// m_axis    out  tvalid/tready          tdata=out_byte, tlast=last_byte
//
// load is taken in idle; encode reads the table in ST_LOOK, then drains its finished bytes
// (0 to (MAX_CODE_LEN+7)/8) in ST_DRAIN; flush drains the pending byte with tlast;
// one request is worked on at a time
// reset clears the table at once through per-entry valid flops
// a stalled output simply holds the current byte and the input stays not ready
//
// depends on hcbp_pkg, hcbp_table and huffman_code_bit_packer_defines.svh
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  logic [hcbp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [hcbp_pkg::ModeW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] out_byte
  output logic [hcbp_pkg::ByteW-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import hcbp_pkg::*;

  localparam int unsigned LenW   = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned WordW  = MAX_CODE_LEN + ByteW;
  localparam int unsigned TotW   = $clog2(MAX_CODE_LEN + ByteW + 1);
  localparam int unsigned MaxOut = (MAX_CODE_LEN + ByteW - 1) / ByteW;
  localparam int unsigned IdxW   = (MaxOut > 1) ? $clog2(MaxOut) : 1;
  localparam int unsigned CntW   = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DRAIN
  } state_e;

  state_e                state_q, state_d;
  logic [ByteW-1:0]      pend_byte_q, pend_byte_d;
  logic [CntW-1:0]       pend_cnt_q, pend_cnt_d;
  logic [WordW-1:0]      word_q, word_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       last_idx_q, last_idx_d;
  logic                  last_q, last_d;

  logic                  s_acc, m_acc;
  logic [SymW-1:0]       in_symbol;
  logic [CodeInW-1:0]    in_code;
  logic [LenInW-1:0]     in_len;
  logic [LenW-1:0]       sat_len;
  logic                  tbl_wr, tbl_rd;
  logic [MAX_CODE_LEN-1:0] rd_code;
  logic [LenW-1:0]       rd_len;

  logic [MAX_CODE_LEN:0] len_mask;
  logic [WordW-1:0]      word_new;
  logic [TotW-1:0]       total;
  logic [TotW-1:0]       emit_cnt;

  assign in_symbol = s_axis_tdata_i[SymW-1:0];
  assign in_code   = s_axis_tdata_i[SymW+CodeInW-1:SymW];
  assign in_len    = s_axis_tdata_i[SymW+CodeInW+LenInW-1:SymW+CodeInW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  assign sat_len = (in_len > LenInW'(MAX_CODE_LEN)) ? LenW'(MAX_CODE_LEN)
                                                     : in_len[LenW-1:0];
  assign tbl_wr = s_acc && (mode_e'(s_axis_tuser_i) == MODE_LOAD);
  assign tbl_rd = s_acc && (mode_e'(s_axis_tuser_i) == MODE_ENCODE);

  hcbp_table #(
    .CodeW(MAX_CODE_LEN),
    .LenW (LenW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (tbl_wr),
    .wr_addr_i(in_symbol),
    .wr_code_i(in_code[MAX_CODE_LEN-1:0]),
    .wr_len_i (sat_len),
    .rd_en_i  (tbl_rd),
    .rd_addr_i(in_symbol),
    .rd_code_o(rd_code),
    .rd_len_o (rd_len)
  );

  // pending bits sit below the masked code, which starts at the fill count
  assign len_mask = ~({(MAX_CODE_LEN + 1){1'b1}} << rd_len);
  assign word_new = WordW'(pend_byte_q)
                  | (WordW'(rd_code & len_mask[MAX_CODE_LEN-1:0]) << pend_cnt_q);
  assign total    = TotW'(pend_cnt_q) + TotW'(rd_len);
  // a byte leaves only once a later bit exists
  assign emit_cnt = (total - TotW'(1)) >> 3;

  always_comb begin
    state_d     = state_q;
    pend_byte_d = pend_byte_q;
    pend_cnt_d  = pend_cnt_q;
    word_d      = word_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (mode_e'(s_axis_tuser_i))
            MODE_ENCODE: begin
              state_d = ST_LOOK;
            end
            MODE_FLUSH: begin
              word_d      = WordW'(pend_byte_q);
              idx_d       = '0;
              last_idx_d  = '0;
              last_d      = 1'b1;
              pend_byte_d = '0;
              pend_cnt_d  = '0;
              state_d     = ST_DRAIN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
        if (rd_len != '0) begin
          word_d      = word_new;
          pend_byte_d = ByteW'(word_new >> {emit_cnt, 3'b000});
          pend_cnt_d  = CntW'(total - {emit_cnt[TotW-4:0], 3'b000});
          idx_d       = '0;
          last_idx_d  = IdxW'(emit_cnt - TotW'(1));
          last_d      = 1'b0;
          if (emit_cnt != '0) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (m_acc) begin
          if (idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_byte_q <= '0;
      pend_cnt_q  <= '0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_byte_q <= pend_byte_d;
      pend_cnt_q  <= pend_cnt_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign m_axis_tvalid_o = (state_q == ST_DRAIN);
  assign m_axis_tdata_o  = ByteW'(word_q >> {idx_q, 3'b000});
  assign m_axis_tlast_o  = last_q;

  `HCBP_ASSERT(a_no_overlap, !(s_axis_tready_o && m_axis_tvalid_o))
  `HCBP_ASSERT(a_cnt_range, pend_cnt_q <= CntW'(ByteW))
  `HCBP_ASSERT(a_last_single, m_axis_tvalid_o && m_axis_tlast_o |-> idx_q == last_idx_q)
  `HCBP_ASSERT(a_drain_holds, m_acc && (idx_q != last_idx_q) |=> m_axis_tvalid_o)

endmodule

FILE: rtl/hcbp_table.sv
// 256-entry code table: synchronous memory with a registered read
// per-entry valid flops make unwritten entries read as zero after reset
// depends on hcbp_pkg
module hcbp_table #(
  parameter int unsigned CodeW = 32,
  parameter int unsigned LenW  = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [hcbp_pkg::SymW-1:0]   wr_addr_i,
  input  logic [CodeW-1:0]            wr_code_i,
  input  logic [LenW-1:0]             wr_len_i,
  input  logic                        rd_en_i,
  input  logic [hcbp_pkg::SymW-1:0]   rd_addr_i,
  output logic [CodeW-1:0]            rd_code_o,
  output logic [LenW-1:0]             rd_len_o
);
  import hcbp_pkg::*;

  logic [CodeW+LenW-1:0] mem [TableDepth];
  logic [TableDepth-1:0] valid_q;
  logic [CodeW+LenW-1:0] rd_data_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_len_i, wr_code_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_code_o = rd_valid_q ? rd_data_q[CodeW-1:0] : '0;
  assign rd_len_o  = rd_valid_q ? rd_data_q[CodeW+LenW-1:CodeW] : '0;

endmodule
